// ===== rtl/tclc_pkg.sv =====
// Shared types, constants and helper functions for the text cell layer compositor.
`timescale 1ns / 1ps

package tclc_pkg;

    localparam int GLYPH_W = 21;
    localparam int RGBA_W  = 32;
    localparam int RGB_W   = 24;
    localparam int CH_W    = 8;
    localparam int SUM_W   = 16;
    localparam int NUM_CH  = 3;

    localparam logic [GLYPH_W-1:0] SPACE_CODE  = 21'h000020;
    localparam logic [CH_W-1:0]    ALPHA_ONE   = 8'd255;
    localparam logic [SUM_W-1:0]   ROUND_HALF  = 16'd127;
    localparam logic [31:0]        RECIP_255   = 32'd32897;
    localparam int                 RECIP_SHIFT = 23;

    // Side data that rides along with the background through the blend stages.
    typedef struct packed {
        logic [GLYPH_W-1:0] glyph;
        logic [RGB_W-1:0]   fore;
        logic               ovl_en;
        logic [RGBA_W-1:0]  ovl_back;
    } cell_side_t;

    // A layer is empty when it shows a space and both colors are all zero.
    function automatic logic is_empty(input logic [GLYPH_W-1:0] glyph,
                                      input logic [RGBA_W-1:0]  fore,
                                      input logic [RGBA_W-1:0]  back);
        return (glyph == SPACE_CODE) && (fore == '0) && (back == '0);
    endfunction

    function automatic logic [RGB_W-1:0] rgba_to_rgb(input logic [RGBA_W-1:0] rgba);
        return rgba[RGBA_W-1:CH_W];
    endfunction

    // Exact x / 255 for x below 65280, as a multiply by a scaled reciprocal.
    function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [31:0] prod;
        prod = {16'b0, x} * RECIP_255;
        return prod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    endfunction

endpackage

// ===== rtl/tclc_select.sv =====
// Input stage: layer emptiness tests, layer choice and glyph/foreground resolution.
`timescale 1ns / 1ps

module tclc_select (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          valid_in,
    input  logic [tclc_pkg::GLYPH_W-1:0]  primary_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   primary_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   primary_back,
    input  logic [tclc_pkg::GLYPH_W-1:0]  secondary_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   secondary_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   secondary_back,
    input  logic [tclc_pkg::GLYPH_W-1:0]  base_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   base_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   base_back,
    input  logic [tclc_pkg::GLYPH_W-1:0]  overlay_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   overlay_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   overlay_back,
    output logic                          valid_out,
    output logic                          prim_en,
    output logic [tclc_pkg::RGBA_W-1:0]   prim_back,
    output logic [tclc_pkg::RGB_W-1:0]    base_rgb,
    output tclc_pkg::cell_side_t          side
);
    import tclc_pkg::*;

    logic                 valid_reg;
    logic                 prim_en_reg,  prim_en_next;
    logic [RGBA_W-1:0]    prim_back_reg;
    logic [RGB_W-1:0]     base_rgb_reg;
    cell_side_t           side_reg,     side_next;
    logic                 prim_empty, sec_empty, ovl_empty;

    always_comb
    begin
        prim_empty = is_empty(primary_glyph, primary_fore, primary_back);
        sec_empty  = is_empty(secondary_glyph, secondary_fore, secondary_back);
        ovl_empty  = is_empty(overlay_glyph, overlay_fore, overlay_back);
        prim_en_next = !prim_empty;

        if (!prim_empty)
        begin
            side_next.glyph = primary_glyph;
            side_next.fore  = rgba_to_rgb(primary_fore);
        end
        else if (!sec_empty)
        begin
            side_next.glyph = secondary_glyph;
            side_next.fore  = rgba_to_rgb(secondary_fore);
        end
        else
        begin
            side_next.glyph = base_glyph;
            side_next.fore  = rgba_to_rgb(base_fore);
        end

        // The overlay wins glyph and foreground outright; only its background blends.
        if (!ovl_empty)
        begin
            side_next.glyph = overlay_glyph;
            side_next.fore  = rgba_to_rgb(overlay_fore);
        end
        side_next.ovl_en   = !ovl_empty;
        side_next.ovl_back = overlay_back;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            prim_en_reg   <= prim_en_next;
            prim_back_reg <= primary_back;
            base_rgb_reg  <= rgba_to_rgb(base_back);
            side_reg      <= side_next;
        end
    end

    assign valid_out = valid_reg;
    assign prim_en   = prim_en_reg;
    assign prim_back = prim_back_reg;
    assign base_rgb  = base_rgb_reg;
    assign side      = side_reg;

endmodule

// ===== rtl/tclc_blend.sv =====
// Two-stage alpha-over blend of an RGBA source onto an RGB destination.
`timescale 1ns / 1ps

module tclc_blend (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         valid_in,
    input  logic                         en_in,
    input  logic [tclc_pkg::RGBA_W-1:0]  src_rgba,
    input  logic [tclc_pkg::RGB_W-1:0]   dst_rgb,
    input  tclc_pkg::cell_side_t         side_in,
    output logic                         valid_out,
    output logic [tclc_pkg::RGB_W-1:0]   rgb_out,
    output tclc_pkg::cell_side_t         side_out
);
    import tclc_pkg::*;

    // Stage 1: weighted sums per channel.
    logic                 v1_reg;
    logic                 en1_reg;
    logic [RGB_W-1:0]     dst1_reg;
    cell_side_t           side1_reg;
    logic [SUM_W-1:0]     sum_reg  [NUM_CH];
    logic [SUM_W-1:0]     sum_next [NUM_CH];

    // Stage 2: divide by 255 and choose.
    logic                 v2_reg;
    logic [RGB_W-1:0]     rgb2_reg, rgb2_next;
    cell_side_t           side2_reg;

    logic [CH_W-1:0]      alpha;
    logic [CH_W-1:0]      inv_alpha;
    logic [RGB_W-1:0]     src_rgb;

    always_comb
    begin
        alpha     = src_rgba[CH_W-1:0];
        inv_alpha = ALPHA_ONE - alpha;
        src_rgb   = rgba_to_rgb(src_rgba);
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum_next[c] = {8'b0, src_rgb[c*CH_W +: CH_W]} * {8'b0, alpha}
                        + {8'b0, dst_rgb[c*CH_W +: CH_W]} * {8'b0, inv_alpha}
                        + ROUND_HALF;
        end
    end

    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            rgb2_next[c*CH_W +: CH_W] = en1_reg ? div255(sum_reg[c])
                                                : dst1_reg[c*CH_W +: CH_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid_in)
        begin
            en1_reg   <= en_in;
            dst1_reg  <= dst_rgb;
            side1_reg <= side_in;
            for (int c = 0; c < NUM_CH; c++)
            begin
                sum_reg[c] <= sum_next[c];
            end
        end
        if (v1_reg)
        begin
            rgb2_reg  <= rgb2_next;
            side2_reg <= side1_reg;
        end
    end

    assign valid_out = v2_reg;
    assign rgb_out   = rgb2_reg;
    assign side_out  = side2_reg;

endmodule

// ===== rtl/text_cell_layer_compositor_top.sv =====
// Top level of the text cell layer compositor pipeline.
`timescale 1ns / 1ps

// Text cell layer compositor.
//
// Input channel: raise start with the twelve layer fields of one cell; the word
// is taken at any rising edge where start is high and busy is low. busy is tied
// low because the pipeline never stalls, so a new cell may enter every cycle.
//
// Output channel: done is high for exactly one cycle with out_glyph,
// out_fore_rgb and out_back_rgb holding the composited cell. The receiver
// cannot push back, and none is needed since nothing ever backs up inside.
//
// The cell passes through one register for layer selection, two for the
// primary-over-base background blend (products, then the divide by 255) and
// two for the overlay blend. Throughput is one cell per clock, set by the fully
// pipelined multiplier stages.
//
// Reset clears only the valid bits along the pipeline; payload registers hold
// whatever they had, and no done pulse comes out for cells lost to a reset.
module text_cell_layer_compositor_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tclc_pkg::GLYPH_W-1:0]  primary_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   primary_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   primary_back,
    input  logic [tclc_pkg::GLYPH_W-1:0]  secondary_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   secondary_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   secondary_back,
    input  logic [tclc_pkg::GLYPH_W-1:0]  base_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   base_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   base_back,
    input  logic [tclc_pkg::GLYPH_W-1:0]  overlay_glyph,
    input  logic [tclc_pkg::RGBA_W-1:0]   overlay_fore,
    input  logic [tclc_pkg::RGBA_W-1:0]   overlay_back,
    output logic                          done,
    output logic [tclc_pkg::GLYPH_W-1:0]  out_glyph,
    output logic [tclc_pkg::RGB_W-1:0]    out_fore_rgb,
    output logic [tclc_pkg::RGB_W-1:0]    out_back_rgb
);
    import tclc_pkg::*;

    logic                 accept;
    logic                 sel_valid;
    logic                 sel_prim_en;
    logic [RGBA_W-1:0]    sel_prim_back;
    logic [RGB_W-1:0]     sel_base_rgb;
    cell_side_t           sel_side;

    logic                 mid_valid;
    logic [RGB_W-1:0]     mid_back;
    cell_side_t           mid_side;

    logic                 fin_valid;
    logic [RGB_W-1:0]     fin_back;
    cell_side_t           fin_side;

    // The pipeline always moves, so a word is never refused.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    tclc_select u_select (
        .clk             (clk),
        .rst_n           (rst_n),
        .valid_in        (accept),
        .primary_glyph   (primary_glyph),
        .primary_fore    (primary_fore),
        .primary_back    (primary_back),
        .secondary_glyph (secondary_glyph),
        .secondary_fore  (secondary_fore),
        .secondary_back  (secondary_back),
        .base_glyph      (base_glyph),
        .base_fore       (base_fore),
        .base_back       (base_back),
        .overlay_glyph   (overlay_glyph),
        .overlay_fore    (overlay_fore),
        .overlay_back    (overlay_back),
        .valid_out       (sel_valid),
        .prim_en         (sel_prim_en),
        .prim_back       (sel_prim_back),
        .base_rgb        (sel_base_rgb),
        .side            (sel_side)
    );

    // Primary background over the canvas; secondary and base keep the canvas color.
    tclc_blend u_blend_primary (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sel_valid),
        .en_in     (sel_prim_en),
        .src_rgba  (sel_prim_back),
        .dst_rgb   (sel_base_rgb),
        .side_in   (sel_side),
        .valid_out (mid_valid),
        .rgb_out   (mid_back),
        .side_out  (mid_side)
    );

    // Overlay background over whatever the lower layers produced.
    tclc_blend u_blend_overlay (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (mid_valid),
        .en_in     (mid_side.ovl_en),
        .src_rgba  (mid_side.ovl_back),
        .dst_rgb   (mid_back),
        .side_in   (mid_side),
        .valid_out (fin_valid),
        .rgb_out   (fin_back),
        .side_out  (fin_side)
    );

    assign done         = fin_valid;
    assign out_glyph    = fin_side.glyph;
    assign out_fore_rgb = fin_side.fore;
    assign out_back_rgb = fin_back;

    // A done pulse must trace back to a word accepted at the pipeline input.
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("done without a matching accepted word");

    // A non-empty overlay always supplies the glyph and foreground.
    a_overlay_wins: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accept && !is_empty(overlay_glyph, overlay_fore, overlay_back), 5)
        |-> out_glyph == $past(overlay_glyph, 5)
            && out_fore_rgb == $past(overlay_fore[RGBA_W-1:CH_W], 5))
        else $error("overlay glyph or foreground lost");

    // An empty overlay with an opaque primary returns the primary background as is.
    a_opaque_primary: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(accept && !is_empty(primary_glyph, primary_fore, primary_back)
                      && is_empty(overlay_glyph, overlay_fore, overlay_back)
                      && primary_back[CH_W-1:0] == ALPHA_ONE, 5)
        |-> out_back_rgb == $past(primary_back[RGBA_W-1:CH_W], 5))
        else $error("opaque primary background altered");

endmodule
